FILE: src/ssr_pkg.sv
// Shared types, widths and constants for the sector sum ratio block.
// No dependencies; every other file in src refers to this package.
package ssr_pkg;

  localparam int PIXEL_W  = 16;
  localparam int POS_W    = 9;
  localparam int SUM_W    = 31;
  localparam int RATIO_W  = 24;
  localparam int SECTOR_W = 3;

  localparam int NUM_SECTORS  = 8;
  localparam int NUM_COLS     = 4;
  localparam int NUM_ROWS     = 2;
  localparam int RIGHT_ORIGIN = 256;

  // Box bounds are compared at this width so that far edges never wrap
  localparam int BOUND_W = 12;

  localparam int SECTOR_WIDTH_DEF  = 64;
  localparam int SECTOR_HEIGHT_DEF = 256;

  // Quotient bits produced by the restoring divider, one per step
  localparam int DIV_STEPS = RATIO_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);
  // Fraction bits of the Q8.16 ratio
  localparam int FRAC_W    = 16;
  // Integer bits of the ratio; quotient saturates once num >= den << INT_W
  localparam int INT_W     = RATIO_W - FRAC_W;

  localparam logic [RATIO_W-1:0]  RATIO_MAX  = '1;
  localparam logic [SECTOR_W-1:0] LAST_SECTOR = SECTOR_W'(NUM_SECTORS - 1);

  typedef logic [SUM_W-1:0]   sum_t;
  typedef logic [RATIO_W-1:0] ratio_t;

  typedef enum logic [4:0] {
    ST_ACCUM = 5'b00001,
    ST_LOAD  = 5'b00010,
    ST_CHECK = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

  typedef struct packed {
    logic accum;   // add the pixel of this transfer into its boxes
    logic load;    // take sector 0 operands, shift the sums down by one sector
    logic check;   // flag zero and saturation, seed the divider
    logic step;    // one restoring division step
  } dp_cmd_t;

  // Magnitude of a two's complement sum; the most negative value maps to 2^30
  function automatic sum_t magnitude(sum_t v);
    sum_t m;
    m = v[SUM_W-1] ? (~v + sum_t'(1)) : v;
    return m;
  endfunction

endpackage

FILE: src/ssr_in_if.sv
// Pixel input channel: valid/ready handshake with pixel, coordinates and frame end.
// Depends on ssr_pkg for field widths.
interface ssr_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [ssr_pkg::PIXEL_W-1:0] pixel;
  logic [ssr_pkg::POS_W-1:0]          pos_x;
  logic [ssr_pkg::POS_W-1:0]          pos_y;
  logic                              frame_end;

  modport source (output valid, pixel, pos_x, pos_y, frame_end, input ready);
  modport sink   (input valid, pixel, pos_x, pos_y, frame_end, output ready);
endinterface

FILE: src/ssr_out_if.sv
// Ratio result channel: valid/ready handshake with sector, ratio and flags.
// Depends on ssr_pkg for field widths.
interface ssr_out_if;
  logic                          valid;
  logic                          ready;
  logic [ssr_pkg::SECTOR_W-1:0]  sector;
  logic [ssr_pkg::RATIO_W-1:0]   ratio;
  logic                          zero_divisor;
  logic                          last;

  modport source (output valid, sector, ratio, zero_divisor, last, input ready);
  modport sink   (input valid, sector, ratio, zero_divisor, last, output ready);
endinterface

FILE: src/ssr_ctrl.sv
// Sequencing state machine: accumulate, then per sector load, check, divide, emit.
// Depends on ssr_pkg; drives ssr_datapath through dp_cmd_t.
module ssr_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_frame_end,
  output logic                         in_ready,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [ssr_pkg::SECTOR_W-1:0] sector,
  output logic                         last,
  output ssr_pkg::dp_cmd_t             cmd
);

  ssr_pkg::state_t               state, state_next;
  logic [ssr_pkg::SECTOR_W-1:0]  sector_next;
  logic [ssr_pkg::STEP_W-1:0]    step_cnt, step_cnt_next;
  logic                          in_xfer, out_xfer;

  assign in_ready  = (state == ssr_pkg::ST_ACCUM);
  assign out_valid = (state == ssr_pkg::ST_EMIT);
  assign in_xfer   = in_valid && in_ready;
  assign out_xfer  = out_valid && out_ready;
  assign last      = (sector == ssr_pkg::LAST_SECTOR);

  always_comb begin
    state_next    = state;
    sector_next   = sector;
    step_cnt_next = step_cnt;
    cmd           = '0;
    case (state)
      ssr_pkg::ST_ACCUM: begin
        cmd.accum = in_xfer;
        if (in_xfer && in_frame_end) begin
          state_next  = ssr_pkg::ST_LOAD;
          sector_next = '0;
        end
      end
      ssr_pkg::ST_LOAD: begin
        cmd.load   = 1'b1;
        state_next = ssr_pkg::ST_CHECK;
      end
      ssr_pkg::ST_CHECK: begin
        cmd.check     = 1'b1;
        step_cnt_next = '0;
        state_next    = ssr_pkg::ST_DIV;
      end
      ssr_pkg::ST_DIV: begin
        cmd.step      = 1'b1;
        step_cnt_next = step_cnt + 1'b1;
        if (step_cnt == ssr_pkg::STEP_W'(ssr_pkg::DIV_STEPS - 1)) begin
          state_next = ssr_pkg::ST_EMIT;
        end
      end
      ssr_pkg::ST_EMIT: begin
        if (out_xfer) begin
          if (last) begin
            state_next = ssr_pkg::ST_ACCUM;
          end else begin
            sector_next = sector + 1'b1;
            state_next  = ssr_pkg::ST_LOAD;
          end
        end
      end
      default: begin
        state_next = ssr_pkg::ST_ACCUM;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ssr_pkg::ST_ACCUM;
      sector   <= '0;
      step_cnt <= '0;
    end else begin
      state    <= state_next;
      sector   <= sector_next;
      step_cnt <= step_cnt_next;
    end
  end

endmodule

FILE: src/ssr_datapath.sv
// Box accumulators as a sector shift line, plus a restoring divider for the ratio.
// Depends on ssr_pkg; commanded by ssr_ctrl.
module ssr_datapath #(
  parameter int SECTOR_WIDTH  = ssr_pkg::SECTOR_WIDTH_DEF,
  parameter int SECTOR_HEIGHT = ssr_pkg::SECTOR_HEIGHT_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  ssr_pkg::dp_cmd_t                   cmd,
  input  logic signed [ssr_pkg::PIXEL_W-1:0] pixel,
  input  logic [ssr_pkg::POS_W-1:0]          pos_x,
  input  logic [ssr_pkg::POS_W-1:0]          pos_y,
  output ssr_pkg::ratio_t                    ratio,
  output logic                               zero_divisor
);

  localparam int BW = ssr_pkg::BOUND_W;
  localparam int SW = ssr_pkg::SUM_W;
  localparam int NS = ssr_pkg::NUM_SECTORS;

  ssr_pkg::sum_t left_sum  [NS];
  ssr_pkg::sum_t right_sum [NS];
  logic [NS-1:0] hit_left, hit_right;
  ssr_pkg::sum_t pix_ext;
  logic [BW-1:0] x_ext, y_ext;

  assign pix_ext = {{(SW - ssr_pkg::PIXEL_W){pixel[ssr_pkg::PIXEL_W-1]}}, pixel};
  assign x_ext   = BW'(pos_x);
  assign y_ext   = BW'(pos_y);

  for (genvar c = 0; c < ssr_pkg::NUM_COLS; c++) begin : g_col
    for (genvar r = 0; r < ssr_pkg::NUM_ROWS; r++) begin : g_row
      localparam int XL = c * SECTOR_WIDTH;
      localparam int XR = ssr_pkg::RIGHT_ORIGIN + c * SECTOR_WIDTH;
      localparam int Y0 = r * SECTOR_HEIGHT;
      logic y_in;
      assign y_in = (y_ext >= BW'(Y0)) && (y_ext < BW'(Y0 + SECTOR_HEIGHT));
      assign hit_left[c*ssr_pkg::NUM_ROWS + r] =
        y_in && (x_ext >= BW'(XL)) && (x_ext < BW'(XL + SECTOR_WIDTH));
      assign hit_right[c*ssr_pkg::NUM_ROWS + r] =
        y_in && (x_ext >= BW'(XR)) && (x_ext < BW'(XR + SECTOR_WIDTH));
    end
  end

  // Each load moves every sector one place towards index 0 and feeds zero in at
  // the top, so eight loads both present the sectors in order and clear the sums.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NS; i++) begin
        left_sum[i]  <= '0;
        right_sum[i] <= '0;
      end
    end else if (cmd.load) begin
      for (int i = 0; i < NS - 1; i++) begin
        left_sum[i]  <= left_sum[i+1];
        right_sum[i] <= right_sum[i+1];
      end
      left_sum[NS-1]  <= '0;
      right_sum[NS-1] <= '0;
    end else if (cmd.accum) begin
      for (int i = 0; i < NS; i++) begin
        if (hit_left[i])  left_sum[i]  <= left_sum[i]  + pix_ext;
        if (hit_right[i]) right_sum[i] <= right_sum[i] + pix_ext;
      end
    end
  end

  // Divider: quotient < 2^24 unless saturated, so the remainder starts at num >> 8
  // and the low dividend bits {num[7:0], 16'b0} shift out as quotient bits shift in.
  ssr_pkg::sum_t            num, den;
  logic [SW-1:0]            rem;
  ssr_pkg::ratio_t          qs;
  logic                     den_zero, sat;
  logic [SW:0]              trial;
  logic [SW+1:0]            diff;
  logic                     qbit;

  assign trial = {rem, qs[ssr_pkg::RATIO_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, den};
  assign qbit  = !diff[SW+1];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      num <= ssr_pkg::magnitude(left_sum[0]);
      den <= ssr_pkg::magnitude(right_sum[0]);
    end
    if (cmd.check) begin
      den_zero <= (den == '0);
      sat      <= ({{ssr_pkg::INT_W{1'b0}}, num} >= {den, {ssr_pkg::INT_W{1'b0}}});
      rem      <= SW'(num >> ssr_pkg::INT_W);
      qs       <= {num[ssr_pkg::INT_W-1:0], {ssr_pkg::FRAC_W{1'b0}}};
    end else if (cmd.step) begin
      rem <= qbit ? diff[SW-1:0] : trial[SW-1:0];
      qs  <= {qs[ssr_pkg::RATIO_W-2:0], qbit};
    end
  end

  assign ratio        = (den_zero || sat) ? ssr_pkg::RATIO_MAX : qs;
  assign zero_divisor = den_zero;

endmodule

FILE: src/sector_sum_ratio_top.sv
// Top level of the sector sum ratio block: controller plus datapath.
// Depends on ssr_pkg, ssr_in_if, ssr_out_if, ssr_ctrl and ssr_datapath.
//
// Pixels are taken at one per cycle while input is open and added into sixteen
// box sums, eight in the left half of the frame and eight at the same offsets in
// the right half. The transfer that carries frame_end is summed as well and then
// closes input: the eight ratios |left| / |right| (unsigned Q8.16, saturated,
// zero divisor flagged) are produced one after another by a single restoring
// divider, each through load, check, 24 divider steps and an output state that
// holds through any output stall, before input reopens with cleared sums.
module sector_sum_ratio_top #(
  parameter int SECTOR_WIDTH  = ssr_pkg::SECTOR_WIDTH_DEF,
  parameter int SECTOR_HEIGHT = ssr_pkg::SECTOR_HEIGHT_DEF
) (
  input logic       clk,
  input logic       rst,
  ssr_in_if.sink    in_ch,
  ssr_out_if.source out_ch
);

  ssr_pkg::dp_cmd_t cmd;

  ssr_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_ch.valid),
    .in_frame_end (in_ch.frame_end),
    .in_ready     (in_ch.ready),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .sector       (out_ch.sector),
    .last         (out_ch.last),
    .cmd          (cmd)
  );

  ssr_datapath #(
    .SECTOR_WIDTH  (SECTOR_WIDTH),
    .SECTOR_HEIGHT (SECTOR_HEIGHT)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .pixel        (in_ch.pixel),
    .pos_x        (in_ch.pos_x),
    .pos_y        (in_ch.pos_y),
    .ratio        (out_ch.ratio),
    .zero_divisor (out_ch.zero_divisor)
  );

endmodule

FILE: src/ssr_checker.sv
// Port-level checks for sector_sum_ratio_top, attached by the bind below.
// Depends on ssr_pkg and the top level's interface ports.
module ssr_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [ssr_pkg::SECTOR_W-1:0] sector,
  input logic [ssr_pkg::RATIO_W-1:0]  ratio,
  input logic                         zero_divisor,
  input logic                         last
);

  // a waiting result stays offered until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before transfer");

  // input is closed while results of a frame are pending
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input open while results pending");

  a_last_sector: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> sector == ssr_pkg::LAST_SECTOR)
    else $error("last flag on wrong sector");

  a_zero_max: assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_divisor |-> ratio == ssr_pkg::RATIO_MAX)
    else $error("zero divisor without saturated ratio");

  a_reopen: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last |=> in_ready)
    else $error("input not reopened after final result");

endmodule

bind sector_sum_ratio_top ssr_checker u_ssr_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .sector       (out_ch.sector),
  .ratio        (out_ch.ratio),
  .zero_divisor (out_ch.zero_divisor),
  .last         (out_ch.last)
);
